@@ src/pts_pkg.sv @@
// shared types and constants of the periodic task scheduler
`default_nettype none

package pts_pkg;

  // request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  // policy register values
  localparam logic POL_RM  = 1'b0;
  localparam logic POL_EDF = 1'b1;

  // input transaction
  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  task_slot;
    logic [15:0] period;
    logic [15:0] rel_deadline;
    logic [15:0] burst;
  } pts_req_t;

  // result transaction
  typedef struct packed {
    logic        status;
    logic        idle;
    logic [3:0]  run_task;
    logic        completed;
    logic [15:0] lost_mask;
    logic        segment_end;
    logic [3:0]  segment_task;
    logic [15:0] segment_length;
    logic [15:0] killed_mask;
  } pts_rsp_t;

endpackage

`default_nettype wire

@@ src/periodic_task_scheduler.sv @@
// periodic task scheduler top level with slot scan sequencer
// a tick result is valid after two passes over the slot memories, one slot a cycle, each
// draining through the per slot unit, then a pick step and an output step
// loads, finish and unknown requests skip the passes and go straight to the output step
// input stalls until the result reaches the output register, so a new request is
// accepted only after the previous result has been loaded into the output register
// reset clears slots, instances, segment and policy; no clearing pass is needed
`default_nettype none

module periodic_task_scheduler
  import pts_pkg::*;
#(
  parameter int TASK_SLOTS = 16,
  parameter int TIME_BITS  = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_data_i,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire pts_req_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output pts_rsp_t      out_data_o
);

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W  = SLOT_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_PICK,
    S_SCAN_B,
    S_DONE
  } state_e;

  // per slot run time state, cleared by valid bits
  typedef struct packed {
    logic [TIME_BITS-1:0] rem;
    logic [TIME_BITS-1:0] dl;
    logic [TIME_BITS-1:0] cd;
  } dyn_t;

  // per slot task parameters
  typedef struct packed {
    logic [TIME_BITS-1:0] per;
    logic [TIME_BITS-1:0] dln;
    logic [TIME_BITS-1:0] bur;
  } sta_t;

  state_e                 state_q;
  logic                   policy_q;
  logic [TASK_SLOTS-1:0]  slot_valid_q;
  logic [TASK_SLOTS-1:0]  active_q;
  logic [TASK_SLOTS-1:0]  dyn_valid_q;
  logic                   seg_open_q;
  logic [SLOT_W-1:0]      seg_slot_q;
  logic [TIME_BITS-1:0]   seg_ticks_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [SLOT_W-1:0]      proc_idx_q;
  logic                   proc_on_q;
  logic                   found_q;
  logic [SLOT_W-1:0]      best_idx_q;
  logic [TIME_BITS-1:0]   best_key_q;
  logic                   best_rel_q;
  pts_rsp_t               res_q;
  pts_rsp_t               out_q;
  logic                   out_valid_q;

  dyn_t                   dyn_mem [TASK_SLOTS];
  sta_t                   sta_mem [TASK_SLOTS];
  dyn_t                   dyn_rd_q;
  sta_t                   sta_rd_q;

  logic                   in_acc;
  logic                   issue_en;
  logic [SLOT_W-1:0]      rd_addr;
  logic                   last_proc;
  logic                   done_fire;
  pts_rsp_t               req_rsp;

  // load field conversion and validation
  logic [TIME_BITS+15:0]  per_ext;
  logic [TIME_BITS+15:0]  dln_ext;
  logic [TIME_BITS+15:0]  bur_ext;
  sta_t                   ld_word;
  logic                   ld_ok;
  logic [SLOT_W-1:0]      ld_idx;
  logic                   sta_we;

  logic [TASK_SLOTS+15:0] pend_ext;
  logic [TIME_BITS+15:0]  seg_ext;
  logic                   seg_close;

  // per slot unit signals
  logic                   pu_sv;
  logic                   pu_act;
  dyn_t                   pu_cur;
  dyn_t                   pu_nxt;
  logic                   pu_act_n;
  logic                   pu_lost;
  logic                   pu_rel;
  logic                   pu_done;
  logic [TIME_BITS-1:0]   pu_key;
  logic                   pu_better;
  logic                   dyn_we;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign done_fire   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // load fields masked to the time width
  assign per_ext     = {{TIME_BITS{1'b0}}, in_data_i.period};
  assign dln_ext     = {{TIME_BITS{1'b0}}, in_data_i.rel_deadline};
  assign bur_ext     = {{TIME_BITS{1'b0}}, in_data_i.burst};
  assign ld_word     = {per_ext[TIME_BITS-1:0], dln_ext[TIME_BITS-1:0],
                        bur_ext[TIME_BITS-1:0]};
  assign ld_idx      = SLOT_W'(in_data_i.task_slot);
  assign ld_ok       = (32'(in_data_i.task_slot) < TASK_SLOTS)
                    && (ld_word.per != '0) && (ld_word.dln != '0) && (ld_word.bur != '0)
                    && (ld_word.bur <= ld_word.dln) && (ld_word.dln <= ld_word.per);
  assign sta_we      = in_acc && (in_data_i.req_type == REQ_LOAD) && ld_ok;

  // pending instances for the finish report, low 16 slots only
  assign pend_ext = {16'b0, slot_valid_q & active_q};
  assign seg_ext  = {16'b0, seg_ticks_q};

  // scan addressing
  assign issue_en  = ((state_q == S_SCAN_A) || (state_q == S_SCAN_B))
                  && (32'(cnt_q) < TASK_SLOTS);
  assign rd_addr   = cnt_q[SLOT_W-1:0];
  assign last_proc = proc_on_q && (proc_idx_q == SLOT_W'(TASK_SLOTS - 1));

  // segment closes when the pick changes, stops or is a fresh instance
  assign seg_close = seg_open_q && (!found_q || (best_idx_q != seg_slot_q) || best_rel_q);

  // starting result of an accepted request
  always_comb begin
    req_rsp      = '0;
    req_rsp.idle = 1'b1;
    case (in_data_i.req_type)
      REQ_LOAD: begin
        req_rsp.status = !ld_ok;
      end
      REQ_FINISH: begin
        req_rsp.killed_mask = pend_ext[15:0];
        if (seg_open_q) begin
          req_rsp.segment_end    = 1'b1;
          req_rsp.segment_task   = 4'(seg_slot_q);
          req_rsp.segment_length = seg_ext[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  // shared per slot unit: deadline miss check, release and pick in pass a, run and age in pass b
  always_comb begin
    pu_sv    = slot_valid_q[proc_idx_q];
    pu_act   = active_q[proc_idx_q];
    pu_cur   = dyn_valid_q[proc_idx_q] ? dyn_rd_q : '0;
    pu_nxt   = pu_cur;
    pu_act_n = pu_act;
    pu_lost  = 1'b0;
    pu_rel   = 1'b0;
    pu_done  = 1'b0;
    if (state_q == S_SCAN_A) begin
      if (pu_act && (pu_cur.dl == '0)) begin
        pu_act_n   = 1'b0;
        pu_nxt.rem = '0;
        pu_lost    = 1'b1;
      end
      if (pu_cur.cd == '0) begin
        pu_act_n   = 1'b1;
        pu_nxt.rem = sta_rd_q.bur;
        pu_nxt.dl  = sta_rd_q.dln;
        pu_nxt.cd  = sta_rd_q.per;
        pu_rel     = 1'b1;
      end
    end else begin
      if (found_q && (proc_idx_q == best_idx_q)) begin
        pu_nxt.rem = pu_cur.rem - TIME_BITS'(1);
        if (pu_nxt.rem == '0) begin
          pu_done  = 1'b1;
          pu_act_n = 1'b0;
        end
      end
      if (pu_act_n && (pu_cur.dl != '0)) begin
        pu_nxt.dl = pu_cur.dl - TIME_BITS'(1);
      end
      if (pu_cur.cd != '0) begin
        pu_nxt.cd = pu_cur.cd - TIME_BITS'(1);
      end
    end
    pu_key    = (policy_q == POL_EDF) ? pu_nxt.dl : sta_rd_q.per;
    pu_better = pu_act_n && (pu_nxt.rem != '0) && (!found_q || (pu_key < best_key_q));
    dyn_we    = proc_on_q && pu_sv;
  end

  // slot memories
  always_ff @(posedge clk_i) begin
    if (issue_en) begin
      dyn_rd_q <= dyn_mem[rd_addr];
      sta_rd_q <= sta_mem[rd_addr];
    end
    if (dyn_we) begin
      dyn_mem[proc_idx_q] <= pu_nxt;
    end
    if (sta_we) begin
      sta_mem[ld_idx] <= ld_word;
    end
  end

  // sequencer, slot flags, segment tracking and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      policy_q     <= POL_RM;
      slot_valid_q <= '0;
      active_q     <= '0;
      dyn_valid_q  <= '0;
      seg_open_q   <= 1'b0;
      seg_slot_q   <= '0;
      seg_ticks_q  <= '0;
      cnt_q        <= '0;
      proc_idx_q   <= '0;
      proc_on_q    <= 1'b0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_key_q   <= '0;
      best_rel_q   <= 1'b0;
      res_q        <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // config register
      if (cfg_we_i) begin
        policy_q <= cfg_data_i;
      end

      // output transaction loaded or taken
      out_valid_q <= done_fire || (out_valid_q && out_stall_i);

      // scan pipeline follows the read port
      proc_on_q  <= issue_en;
      proc_idx_q <= rd_addr;

      // write back of the per slot unit
      if (dyn_we) begin
        active_q[proc_idx_q]    <= pu_act_n;
        dyn_valid_q[proc_idx_q] <= 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_q      <= req_rsp;
            cnt_q      <= '0;
            found_q    <= 1'b0;
            best_rel_q <= 1'b0;
            state_q    <= (in_data_i.req_type == REQ_TICK) ? S_SCAN_A : S_DONE;
            case (in_data_i.req_type)
              REQ_LOAD: begin
                if (ld_ok) begin
                  slot_valid_q[ld_idx] <= 1'b1;
                  active_q[ld_idx]     <= 1'b0;
                  dyn_valid_q[ld_idx]  <= 1'b0;
                end
              end
              REQ_FINISH: begin
                active_q    <= '0;
                dyn_valid_q <= '0;
                seg_open_q  <= 1'b0;
                seg_slot_q  <= '0;
                seg_ticks_q <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN_A: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (proc_on_q && pu_sv) begin
            if (pu_lost && (32'(proc_idx_q) < 16)) begin
              res_q.lost_mask[4'(proc_idx_q)] <= 1'b1;
            end
            if (pu_better) begin
              found_q    <= 1'b1;
              best_idx_q <= proc_idx_q;
              best_key_q <= pu_key;
              best_rel_q <= pu_rel;
            end
          end
          if (last_proc) begin
            state_q <= S_PICK;
          end
        end

        S_PICK: begin
          if (seg_close) begin
            res_q.segment_end    <= 1'b1;
            res_q.segment_task   <= 4'(seg_slot_q);
            res_q.segment_length <= seg_ext[15:0];
          end
          if (found_q) begin
            res_q.idle     <= 1'b0;
            res_q.run_task <= 4'(best_idx_q);
            if (seg_open_q && !seg_close) begin
              if (seg_ticks_q != '1) begin
                seg_ticks_q <= seg_ticks_q + TIME_BITS'(1);
              end
            end else begin
              seg_open_q  <= 1'b1;
              seg_slot_q  <= best_idx_q;
              seg_ticks_q <= TIME_BITS'(1);
            end
          end else begin
            seg_open_q <= 1'b0;
          end
          cnt_q   <= '0;
          state_q <= S_SCAN_B;
        end

        S_SCAN_B: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (proc_on_q && pu_sv && pu_done) begin
            res_q.completed <= 1'b1;
          end
          if (last_proc) begin
            state_q <= S_DONE;
          end
        end

        S_DONE: begin
          if (done_fire) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
